// File: rtl/dimmer_serial_frame_receiver_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dimmer serial frame receiver
// Concurrent checks clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DIMMER_SERIAL_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define DIMMER_SERIAL_FRAME_RECEIVER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define DSFR_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// Consequent must hold in the cycle after the antecedent.
`define DSFR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`else

`define DSFR_ASSERT_NOW(label, ante, cons)
`define DSFR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: rtl/dsfr_pkg.sv
// ----------------------------------------------------------------------------
// dsfr_pkg
// Types and constants shared by the dimmer serial frame receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dsfr_pkg;

   // Payload counter wraps at this depth.
   localparam int PAYLOAD_DEPTH = 64;
   localparam int CNT_W         = $clog2(PAYLOAD_DEPTH);

   localparam int GAP_W   = 16;
   localparam int POLL_W  = 20;
   localparam int IDLE_W  = 20;
   localparam int CSR_W   = 20;
   localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

   // Frame bytes of interest.
   localparam logic [7:0] START_BYTE = 8'h01;
   localparam logic [7:0] CMD_POWER  = 8'h10;
   localparam logic [7:0] CMD_DIM    = 8'h02;

   // Reset values of the configuration registers.
   localparam logic [GAP_W-1:0]  GAP_LIMIT_RESET     = 16'd600;
   localparam logic [POLL_W-1:0] POLL_INTERVAL_RESET = 20'd10000;

   // Division by 20 is (x >> 2) / 5, done as a reciprocal multiply.
   localparam logic [15:0] DIV5_MAGIC = 16'd52429;
   localparam int          DIV5_SHIFT = 18;
   localparam logic [11:0] POWER_MAX  = 12'd3276;

   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef enum logic {
      CSR_GAP_LIMIT     = 1'b0,
      CSR_POLL_INTERVAL = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      EV_POWER = 2'd0,
      EV_DIM   = 2'd1,
      EV_POLL  = 2'd2
   } event_type;

   typedef enum logic [6:0] {
      ST_START  = 7'b0000001,
      ST_ID     = 7'b0000010,
      ST_CMD    = 7'b0000100,
      ST_LEN    = 7'b0001000,
      ST_DATA   = 7'b0010000,
      ST_CHK_HI = 7'b0100000,
      ST_CHK_LO = 7'b1000000
   } parse_state_type;

endpackage

// File: rtl/dimmer_serial_frame_receiver_unit.sv
// A result is registered: it appears on the rsp_ channel in the cycle after the item that causes it.
// Throughput: one item per cycle; the only limit is a stalled, full result register.
// The frame parser, idle counter and divide-by-20 multiplier are all combinational.
// Reset is synchronous and active high: parsing restarts at the start-byte search,
// all frame state and the idle count clear, and the registers return to 600 and 10000.
// ----------------------------------------------------------------------------
// dimmer_serial_frame_receiver_unit
// Parses serial frames from received bytes, checks the checksum and reports
// power readings, dim completion and due power requests from idle ticks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "dimmer_serial_frame_receiver_unit_assert.svh"

module dimmer_serial_frame_receiver_unit
   import dsfr_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // Configuration write port
   input  logic                      csr_write,
   input  logic                      csr_index,
   input  logic [CSR_W-1:0]          csr_data,
   // Input items
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_operation,
   input  logic [7:0]                req_data_byte,
   // Result items
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_event_kind,
   output logic [11:0]               rsp_power_value,
   output logic [7:0]                rsp_request_id
);

   // Configuration registers
   logic [GAP_W-1:0]  gap_limit_ff;
   logic [POLL_W-1:0] poll_interval_ff;

   // Parser state
   parse_state_type   state_ff, state_in;
   logic [7:0]        frame_id_ff, frame_id_in;
   logic [7:0]        frame_cmd_ff, frame_cmd_in;
   logic [7:0]        frame_len_ff, frame_len_in;
   logic [CNT_W-1:0]  pay_cnt_ff, pay_cnt_in;
   logic [15:0]       frame_sum_ff, frame_sum_in;
   logic [7:0]        pay_six_ff, pay_six_in;
   logic [7:0]        pay_seven_ff, pay_seven_in;
   logic [IDLE_W-1:0] idle_ff, idle_in;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_kind_ff, rsp_kind_in;
   logic [11:0]       rsp_power_ff, rsp_power_in;
   logic [7:0]        rsp_id_ff, rsp_id_in;

   logic              req_accept;
   logic              emit;
   parse_state_type   state_eff;
   logic [IDLE_W-1:0] idle_inc;
   logic              poll_due;
   logic [CNT_W:0]    cnt_next;
   logic [CNT_W-1:0]  cnt_wrap;
   logic [15:0]       sum_add;
   logic [15:0]       sum_dec;
   logic [29:0]       power_prod;
   logic              byte_accept;
   logic              poll_accept;

   // The input side is held off only while a finished result is stuck.
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         gap_limit_ff     <= GAP_LIMIT_RESET;
         poll_interval_ff <= POLL_INTERVAL_RESET;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_GAP_LIMIT:     gap_limit_ff     <= csr_data[GAP_W-1:0];
            CSR_POLL_INTERVAL: poll_interval_ff <= csr_data[POLL_W-1:0];
            default:           gap_limit_ff     <= gap_limit_ff;
         endcase
      end
   end

   // Helpers for the byte and tick paths.
   assign state_eff  = (idle_ff > IDLE_W'(gap_limit_ff)) ? ST_START : state_ff;
   assign idle_inc   = (idle_ff < IDLE_MAX) ? idle_ff + 1'b1 : idle_ff;
   assign poll_due   = idle_inc > poll_interval_ff;
   assign cnt_next   = {1'b0, pay_cnt_ff} + 1'b1;
   assign cnt_wrap   = (cnt_next >= (CNT_W+1)'(PAYLOAD_DEPTH)) ? '0 : cnt_next[CNT_W-1:0];
   assign sum_add    = frame_sum_ff + {8'd0, req_data_byte};
   assign sum_dec    = frame_sum_ff - 16'd1;
   // Power in units of the raw reading divided by 20.
   assign power_prod = {pay_seven_ff, pay_six_ff[7:2]} * DIV5_MAGIC;

   // Next-state and result logic for one accepted item.
   always_comb begin
      state_in     = state_ff;
      frame_id_in  = frame_id_ff;
      frame_cmd_in = frame_cmd_ff;
      frame_len_in = frame_len_ff;
      pay_cnt_in   = pay_cnt_ff;
      frame_sum_in = frame_sum_ff;
      pay_six_in   = pay_six_ff;
      pay_seven_in = pay_seven_ff;
      idle_in      = idle_ff;
      emit         = 1'b0;
      rsp_kind_in  = EV_POWER;
      rsp_power_in = '0;
      rsp_id_in    = '0;

      if (req_accept) begin
         if (op_type'(req_operation) == OP_TICK) begin
            // Idle tick: count, and raise a power request once overdue.
            idle_in = idle_inc;
            if (poll_due) begin
               idle_in     = '0;
               emit        = 1'b1;
               rsp_kind_in = EV_POLL;
               rsp_id_in   = frame_id_ff + 8'd1;
            end
         end else begin
            // Received byte; a long gap before it restarts the start search.
            idle_in  = '0;
            state_in = state_eff;
            unique case (state_eff)
               ST_START: begin
                  if (req_data_byte == START_BYTE) begin
                     frame_sum_in = {8'd0, req_data_byte};
                     state_in     = ST_ID;
                  end
               end
               ST_ID: begin
                  frame_id_in  = req_data_byte;
                  frame_sum_in = sum_add;
                  state_in     = ST_CMD;
               end
               ST_CMD: begin
                  frame_cmd_in = req_data_byte;
                  frame_sum_in = sum_add;
                  state_in     = ST_LEN;
               end
               ST_LEN: begin
                  frame_len_in = req_data_byte;
                  pay_cnt_in   = '0;
                  frame_sum_in = sum_add;
                  state_in     = (req_data_byte == 8'd0) ? ST_CHK_HI : ST_DATA;
               end
               ST_DATA: begin
                  if (pay_cnt_ff == CNT_W'(6)) begin
                     pay_six_in = req_data_byte;
                  end else if (pay_cnt_ff == CNT_W'(7)) begin
                     pay_seven_in = req_data_byte;
                  end
                  pay_cnt_in   = cnt_wrap;
                  frame_sum_in = sum_add;
                  if (8'(cnt_wrap) == frame_len_ff) begin
                     state_in = ST_CHK_HI;
                  end
               end
               ST_CHK_HI: begin
                  frame_sum_in = sum_dec;
                  state_in     = (sum_dec[15:8] == req_data_byte) ? ST_CHK_LO : ST_START;
               end
               ST_CHK_LO: begin
                  state_in = ST_START;
                  if (frame_sum_ff[7:0] == req_data_byte) begin
                     if (frame_cmd_ff == CMD_POWER) begin
                        emit         = 1'b1;
                        rsp_kind_in  = EV_POWER;
                        rsp_power_in = power_prod[DIV5_SHIFT+11:DIV5_SHIFT];
                     end else if (frame_cmd_ff == CMD_DIM) begin
                        emit        = 1'b1;
                        rsp_kind_in = EV_DIM;
                     end
                  end
               end
               default: state_in = ST_START;
            endcase
         end
      end
   end

   // The result register loads on an emitting item and drains when taken.
   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_START;
         frame_id_ff  <= '0;
         frame_cmd_ff <= '0;
         frame_len_ff <= '0;
         pay_cnt_ff   <= '0;
         frame_sum_ff <= '0;
         pay_six_ff   <= '0;
         pay_seven_ff <= '0;
         idle_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         frame_id_ff  <= frame_id_in;
         frame_cmd_ff <= frame_cmd_in;
         frame_len_ff <= frame_len_in;
         pay_cnt_ff   <= pay_cnt_in;
         frame_sum_ff <= frame_sum_in;
         pay_six_ff   <= pay_six_in;
         pay_seven_ff <= pay_seven_in;
         idle_ff      <= idle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_kind_ff  <= rsp_kind_in;
         rsp_power_ff <= rsp_power_in;
         rsp_id_ff    <= rsp_id_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_kind  = rsp_kind_ff;
   assign rsp_power_value = rsp_power_ff;
   assign rsp_request_id  = rsp_id_ff;

   // Accepted bytes, and accepted ticks that raise a power request.
   assign byte_accept = req_accept && op_type'(req_operation) == OP_BYTE;
   assign poll_accept = req_accept && op_type'(req_operation) == OP_TICK && poll_due;

   // Checks on the parser, idle counter and result register.
   `DSFR_ASSERT_NEXT(a_idle_clears, byte_accept || poll_accept, idle_ff == '0)
   `DSFR_ASSERT_NEXT(a_poll_emits, poll_accept, rsp_valid_ff && rsp_kind_ff == EV_POLL)
   `DSFR_ASSERT_NOW(a_power_range, rsp_valid_ff && rsp_kind_ff == EV_POWER, rsp_power_ff <= POWER_MAX)
   `DSFR_ASSERT_NOW(a_power_zero, rsp_valid_ff && rsp_kind_ff != EV_POWER, rsp_power_ff == '0)
   `DSFR_ASSERT_NOW(a_cnt_range, 1'b1, pay_cnt_ff <= CNT_W'(PAYLOAD_DEPTH - 1))

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dimmer serial frame receiver. A short table of
// hand-built frames and ticks runs first, then random bursts of good, broken
// and oversized frames mixed with tick runs, under several register settings.
// Every accepted item goes through a cycle-free copy of the parser, and each
// event that comes out is compared field by field with the oldest one queued.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import dsfr_pkg::*;

   // One event as it leaves the block.
   typedef struct packed {
      event_type   kind;
      logic [11:0] power;
      logic [7:0]  id;
   } frame_event_type;

   // Directed rows either carry their event or leave it to the parser copy.
   typedef enum logic {
      ROW_PREDICT = 1'b0,
      ROW_GIVEN   = 1'b1
   } row_check_type;

   typedef struct {
      op_type          op;
      logic [7:0]      data;
      row_check_type   check;
      frame_event_type want;
   } stim_row_type;

   // Block ports; the inputs are at known values from time zero.
   logic              clock         = 1'b0;
   logic              reset         = 1'b1;
   logic              csr_write     = 1'b0;
   logic              csr_index     = 1'b0;
   logic [CSR_W-1:0]  csr_data      = '0;
   logic              req_valid     = 1'b0;
   logic              req_stall;
   logic              req_operation = 1'b0;
   logic [7:0]        req_data_byte = '0;
   logic              rsp_valid;
   logic              rsp_stall     = 1'b0;
   logic [1:0]        rsp_event_kind;
   logic [11:0]       rsp_power_value;
   logic [7:0]        rsp_request_id;

   // Parser copy: configuration and frame state.
   logic [GAP_W-1:0]  gap_lim    = GAP_LIMIT_RESET;
   logic [POLL_W-1:0] poll_lim   = POLL_INTERVAL_RESET;
   parse_state_type   rx_state   = ST_START;
   logic [7:0]        rx_id      = '0;
   logic [7:0]        rx_cmd     = '0;
   logic [7:0]        rx_len     = '0;
   int unsigned       rx_count   = 0;
   logic [15:0]       rx_sum     = '0;
   logic [7:0]        rx_b6      = '0;
   logic [7:0]        rx_b7      = '0;
   logic [IDLE_W-1:0] idle_cnt   = '0;

   // Events still owed by the block, oldest first.
   frame_event_type   pending[$];
   stim_row_type      directed_rows[$];
   frame_event_type   want_ev;

   // Shared control between the sender, the receiver and the main sequence.
   bit                calm          = 1'b0;
   bit                hold_off_req  = 1'b0;

   int                mismatches    = 0;
   int                items_accepted = 0;
   int                expected_total = 0;
   int                results_checked = 0;
   int                power_seen    = 0;
   int                dim_seen      = 0;
   int                poll_seen     = 0;
   int                settings_used = 0;
   int                wrap_frames   = 0;

   dimmer_serial_frame_receiver_unit dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_power_value (rsp_power_value),
      .rsp_request_id  (rsp_request_id)
   );

   // 12 ns clock.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Prints one line per mismatch, up to a cap, and counts every one.
   task automatic flag_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 40) begin
         $display("[%0t] mismatch: %s", $time, msg);
      end
   endtask

   // Advances the parser copy by one item; returns 1 when an event comes out.
   function automatic bit predict_frame_event(input op_type op, input logic [7:0] b,
                                              output frame_event_type ev);
      logic [15:0] raw;
      ev.kind  = EV_POWER;
      ev.power = '0;
      ev.id    = '0;
      // A tick counts idle time and may raise a power request.
      if (op == OP_TICK) begin
         if (idle_cnt != IDLE_MAX) begin
            idle_cnt = idle_cnt + 1'b1;
         end
         if (idle_cnt > poll_lim) begin
            idle_cnt = '0;
            ev.kind  = EV_POLL;
            ev.id    = rx_id + 8'd1;
            return 1'b1;
         end
         return 1'b0;
      end
      // A byte after a long silence restarts the search for a start byte.
      if (idle_cnt > IDLE_W'(gap_lim)) begin
         rx_state = ST_START;
      end
      idle_cnt = '0;
      case (rx_state)
         ST_START: begin
            if (b == START_BYTE) begin
               rx_sum   = 16'(b);
               rx_state = ST_ID;
            end
         end
         ST_ID: begin
            rx_id    = b;
            rx_sum   = rx_sum + 16'(b);
            rx_state = ST_CMD;
         end
         ST_CMD: begin
            rx_cmd   = b;
            rx_sum   = rx_sum + 16'(b);
            rx_state = ST_LEN;
         end
         ST_LEN: begin
            rx_len   = b;
            rx_count = 0;
            rx_sum   = rx_sum + 16'(b);
            if (b == 8'd0) begin
               rx_state = ST_CHK_HI;
            end else begin
               rx_state = ST_DATA;
            end
         end
         ST_DATA: begin
            if (rx_count == 6) begin
               rx_b6 = b;
            end else if (rx_count == 7) begin
               rx_b7 = b;
            end
            rx_count++;
            rx_sum = rx_sum + 16'(b);
            if (rx_count >= PAYLOAD_DEPTH) begin
               rx_count = 0;
            end
            if (rx_count == rx_len) begin
               rx_state = ST_CHK_HI;
            end
         end
         ST_CHK_HI: begin
            rx_sum = rx_sum - 16'd1;
            if (rx_sum[15:8] == b) begin
               rx_state = ST_CHK_LO;
            end else begin
               rx_state = ST_START;
            end
         end
         ST_CHK_LO: begin
            rx_state = ST_START;
            if (rx_sum[7:0] == b) begin
               if (rx_cmd == CMD_POWER) begin
                  raw      = {rx_b7, rx_b6};
                  ev.kind  = EV_POWER;
                  ev.power = 12'(raw / 16'd20);
                  return 1'b1;
               end
               if (rx_cmd == CMD_DIM) begin
                  ev.kind = EV_DIM;
                  return 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      return 1'b0;
   endfunction

   // Offers one item after a random pause and holds it until accepted.
   task automatic send_item(input op_type op, input logic [7:0] b);
      int pause;
      pause = calm ? 0 : $urandom_range(0, 4);
      repeat (pause) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_operation <= op;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
      items_accepted++;
   endtask

   // Sends one item and queues whatever event it should cause.
   task automatic feed(input op_type op, input logic [7:0] b);
      frame_event_type ev;
      send_item(op, b);
      if (predict_frame_event(op, b, ev)) begin
         pending.push_back(ev);
         expected_total++;
      end
   endtask

   // Sends a frame of body payload bytes; stops after cut bytes when cut is
   // not negative. bad picks a corrupted checksum byte: 1 high, 2 low.
   task automatic send_frame(input logic [7:0] id, input logic [7:0] cmd,
                             input logic [7:0] len, input int body, input int cut,
                             input int bad);
      logic [15:0] sum;
      logic [7:0]  b;
      int          k;
      sum = '0;
      for (k = 0; k < 6 + body && k != cut; k++) begin
         if (k == 0) begin
            b = START_BYTE;
         end else if (k == 1) begin
            b = id;
         end else if (k == 2) begin
            b = cmd;
         end else if (k == 3) begin
            b = len;
         end else if (k < 4 + body) begin
            b = 8'($urandom);
         end else if (k == 4 + body) begin
            sum = sum - 16'd1;
            b   = sum[15:8] ^ ((bad == 1) ? 8'($urandom_range(1, 255)) : 8'd0);
         end else begin
            b = sum[7:0] ^ ((bad == 2) ? 8'($urandom_range(1, 255)) : 8'd0);
         end
         if (k < 4 + body) begin
            sum = sum + 16'(b);
         end
         feed(OP_BYTE, b);
      end
   endtask

   // One random burst: mostly well-formed frames, some broken ones and noise,
   // followed by a run of ticks.
   task automatic play_random_burst();
      int         pick;
      int         len;
      int         body;
      int         n;
      int         c;
      logic [7:0] cmd;
      calm = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      len  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 10);
      c    = $urandom_range(0, 9);
      if (c < 4) begin
         cmd = CMD_POWER;
      end else if (c < 7) begin
         cmd = CMD_DIM;
      end else begin
         cmd = 8'($urandom);
      end
      if (pick < 60) begin
         send_frame(8'($urandom), cmd, 8'(len), len, -1, 0);
      end else if (pick < 75) begin
         send_frame(8'($urandom), cmd, 8'(len), len, -1, $urandom_range(1, 2));
      end else if (pick < 85) begin
         // Frame cut short, then, under a small gap limit, silence long enough to restart the search.
         send_frame(8'($urandom), cmd, 8'(len), len, $urandom_range(1, 5 + len), 0);
         if (gap_lim < 100) begin
            repeat (gap_lim + 1) feed(OP_TICK, 8'($urandom));
         end
      end else if (pick < 90 && gap_lim < 64) begin
         // Length past the buffer depth: the counter wraps and only a gap ends it.
         len  = $urandom_range(PAYLOAD_DEPTH, 255);
         body = $urandom_range(PAYLOAD_DEPTH + 1, 140);
         send_frame(8'($urandom), cmd, 8'(len), body, 4 + body, 0);
         repeat (gap_lim + 1) feed(OP_TICK, 8'($urandom));
         wrap_frames++;
      end else begin
         n = $urandom_range(1, 8);
         repeat (n) feed(op_type'($urandom_range(0, 1)), 8'($urandom));
      end
      n = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 80);
      repeat (n) feed(OP_TICK, 8'($urandom));
   endtask

   // Writes one register while the block is idle and mirrors it.
   task automatic write_register(input csr_index_type idx, input logic [CSR_W-1:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_GAP_LIMIT) begin
         gap_lim = val[GAP_W-1:0];
      end else begin
         poll_lim = val;
      end
      settings_used++;
   endtask

   // Stops offering items and waits for every owed event, within a bound.
   task automatic drain_results();
      int w;
      @(negedge clock);
      req_valid <= 1'b0;
      for (w = 0; w < 2000 && pending.size() != 0; w++) begin
         @(posedge clock);
      end
      repeat (3) @(posedge clock);
      if (pending.size() != 0) begin
         flag_mismatch($sformatf("%0d expected results never arrived", pending.size()));
         pending.delete();
      end
   endtask

   // Adds one line to the directed table.
   task automatic add_row(input op_type op, input logic [7:0] data,
                          input row_check_type check = ROW_PREDICT,
                          input event_type kind = EV_POWER,
                          input logic [11:0] power = '0, input logic [7:0] id = '0);
      stim_row_type r;
      r.op         = op;
      r.data       = data;
      r.check      = check;
      r.want.kind  = kind;
      r.want.power = power;
      r.want.id    = id;
      directed_rows.push_back(r);
   endtask

   // Result side: random stalls per item, and one long hold-off on request.
   initial begin : result_sink
      int n;
      int held;
      wait (reset == 1'b0);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            for (held = 0; held < 300; held++) begin
               @(negedge clock);
               rsp_stall <= 1'b1;
            end
         end else begin
            n = calm ? 0 : $urandom_range(0, 4);
            repeat (n) begin
               @(negedge clock);
               rsp_stall <= 1'b1;
            end
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_stall == 1'b0));
      end
   end

   // Compare each accepted event with the oldest one owed.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (pending.size() == 0) begin
            flag_mismatch($sformatf("unexpected event kind %0d", rsp_event_kind));
         end else begin
            want_ev = pending.pop_front();
            results_checked++;
            case (want_ev.kind)
               EV_POWER: power_seen++;
               EV_DIM:   dim_seen++;
               default:  poll_seen++;
            endcase
            if (rsp_event_kind !== want_ev.kind) begin
               flag_mismatch($sformatf("event kind %0d, expected %0d",
                                       rsp_event_kind, want_ev.kind));
            end
            if (rsp_power_value !== want_ev.power) begin
               flag_mismatch($sformatf("power value %0d, expected %0d",
                                       rsp_power_value, want_ev.power));
            end
            if (rsp_request_id !== want_ev.id) begin
               flag_mismatch($sformatf("request id %0d, expected %0d",
                                       rsp_request_id, want_ev.id));
            end
         end
      end
   end

   // Main sequence.
   initial begin : stimulus
      int               p;
      int               start_items;
      logic [GAP_W-1:0]  g;
      logic [POLL_W-1:0] q;
      stim_row_type     r;
      frame_event_type  ev;
      bit               hit;

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Small limits so that gaps and power requests fit in a short table.
      write_register(CSR_GAP_LIMIT, 20'd1);
      write_register(CSR_POLL_INTERVAL, 20'd2);

      // Gap in the middle of a frame: the second start byte begins a new one.
      add_row(OP_BYTE, START_BYTE);
      add_row(OP_BYTE, 8'hFF);
      add_row(OP_TICK, 8'h00);
      add_row(OP_TICK, 8'hFF);
      add_row(OP_BYTE, START_BYTE);
      // Dim frame with zero length; checksum 0x0101.
      add_row(OP_BYTE, 8'hFF);
      add_row(OP_BYTE, CMD_DIM);
      add_row(OP_BYTE, 8'h00);
      add_row(OP_BYTE, 8'h01);
      add_row(OP_BYTE, 8'h01, ROW_GIVEN, EV_DIM);
      // Power request after three ticks; id 0xFF wraps to zero.
      add_row(OP_TICK, 8'h00);
      add_row(OP_TICK, 8'h00);
      add_row(OP_TICK, 8'h00, ROW_GIVEN, EV_POLL, 12'd0, 8'h00);
      // Power frame with 0xFFFF in bytes six and seven; checksum 0x0295.
      add_row(OP_BYTE, START_BYTE);
      add_row(OP_BYTE, 8'h7F);
      add_row(OP_BYTE, CMD_POWER);
      add_row(OP_BYTE, 8'h08);
      repeat (6) add_row(OP_BYTE, 8'h00);
      add_row(OP_BYTE, 8'hFF);
      add_row(OP_BYTE, 8'hFF);
      add_row(OP_BYTE, 8'h02);
      add_row(OP_BYTE, 8'h95, ROW_GIVEN, EV_POWER, POWER_MAX, 8'h00);

      foreach (directed_rows[i]) begin
         r = directed_rows[i];
         send_item(r.op, r.data);
         hit = predict_frame_event(r.op, r.data, ev);
         if (r.check == ROW_GIVEN) begin
            pending.push_back(r.want);
            expected_total++;
         end else if (hit) begin
            pending.push_back(ev);
            expected_total++;
         end
      end

      // Random phases, each under its own register setting.
      for (p = 0; p < 6; p++) begin
         case (p)
            0: begin g = '0;                      q = '0;                  end
            1: begin g = '1;                      q = '1;                  end
            2: begin g = 16'd3;                   q = 20'd7;               end
            3: begin g = 16'd20;                  q = 20'd45;              end
            4: begin g = 16'($urandom_range(0, 40)); q = 20'($urandom_range(0, 70)); end
            default: begin g = GAP_LIMIT_RESET;   q = POLL_INTERVAL_RESET; end
         endcase
         drain_results();
         // Upper bits above the gap limit's width must be dropped.
         write_register(CSR_GAP_LIMIT, {4'($urandom), g});
         write_register(CSR_POLL_INTERVAL, q);
         start_items = items_accepted;
         while (items_accepted - start_items < 90) begin
            play_random_burst();
         end
      end

      // Every tick raises a request while the receiver holds off, so the
      // result register fills and the input side must stall.
      drain_results();
      write_register(CSR_GAP_LIMIT, 20'd5);
      write_register(CSR_POLL_INTERVAL, 20'd0);
      calm         = 1'b1;
      hold_off_req = 1'b1;
      repeat (40) feed(OP_TICK, 8'($urandom));
      calm = 1'b0;

      drain_results();
      $display("Covered %0d items and %0d events (%0d power, %0d dim, %0d requests).",
               items_accepted, results_checked, power_seen, dim_seen, poll_seen);
      $display("Register writes: %0d; wrapped long frames: %0d; one long receiver hold-off.",
               settings_used, wrap_frames);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog far beyond the slowest correct run.
   initial begin : watchdog
      #6000000;
      $display("FAIL");
      $finish;
   end

endmodule
